FILE: src/gated_event_histogrammer_macros.svh
// Assertion macros shared by the histogrammer RTL.
// Include this header by its bare name in files that check their own logic.
`ifndef GATED_EVENT_HISTOGRAMMER_MACROS_SVH
`define GATED_EVENT_HISTOGRAMMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GEH_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GEH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/geh_pkg.sv
// Shared types and constants of the gated event histogrammer.
// Used by the front end, the command queue, the back end and the top level.
package geh_pkg;

   // Fixed field widths of the request, response and register port.
   localparam int CH_W   = 12;
   localparam int ADDR_W = 16;
   localparam int OUT_W  = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   // Depth of the queue between front end and back end.
   localparam int QUEUE_DEPTH = 2;

   // Request opcodes.
   localparam logic [1:0] OP_EVENT  = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Spectrum selection for reads.
   localparam logic [1:0] SEL_POS    = 2'd0;
   localparam logic [1:0] SEL_ENERGY = 2'd1;
   localparam logic [1:0] SEL_PAIR   = 2'd2;
   localparam logic [1:0] SEL_GATED  = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_GATE_ENABLE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GATE_MIN_POS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GATE_MAX_POS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GATE_MIN_ENERGY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GATE_MAX_ENERGY = 3'd4;

   // Kind of work that the back end carries out.
   typedef enum logic [1:0] {
      CMD_EVENT = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_kind_type;

   // Gate box as held in the configuration registers.
   typedef struct packed {
      logic            enable;
      logic [CH_W-1:0] min_pos;
      logic [CH_W-1:0] max_pos;
      logic [CH_W-1:0] min_energy;
      logic [CH_W-1:0] max_energy;
   } gate_cfg_type;

   // Classified command passed from the front end to the back end.
   typedef struct packed {
      cmd_kind_type      kind;
      logic [1:0]        spectrum_select;
      logic              pos_ok;
      logic              energy_ok;
      logic              pair_ok;
      logic              gate_hit;
      logic              read_ok;
      logic [CH_W-1:0]   pos_channel;
      logic [CH_W-1:0]   energy_channel;
      logic [ADDR_W-1:0] read_address;
   } cmd_type;

endpackage

FILE: src/geh_front.sv
// Front end of the histogrammer: accepts requests and classifies them.
// Depends on geh_pkg; feeds classified commands into geh_cmd_queue.
module geh_front #(
   parameter int BINS_1D      = 4096,
   parameter int BINS_2D_SIDE = 256,
   parameter int BIN_SHIFT    = 4
) (
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_opcode,
   input  logic [geh_pkg::CH_W-1:0]  req_pos_channel,
   input  logic [geh_pkg::CH_W-1:0]  req_energy_channel,
   input  logic [1:0]                req_spectrum_select,
   input  logic [geh_pkg::ADDR_W-1:0] req_read_address,
   input  geh_pkg::gate_cfg_type     gate_cfg,
   input  logic                      back_busy,
   output logic                      push_valid,
   input  logic                      push_ready,
   output geh_pkg::cmd_type          push_cmd
);
   import geh_pkg::*;

   localparam int BINS_2D = BINS_2D_SIDE * BINS_2D_SIDE;

   logic [CH_W-1:0] row;
   logic [CH_W-1:0] col;
   logic            in_box;
   logic            known_op;
   logic            addr_1d_ok;
   logic            addr_2d_ok;

   // Requests are taken only while the spectra are not being swept clean.
   assign req_ready  = push_ready && !back_busy;
   assign push_valid = req_valid && !back_busy && known_op;

   // Coordinates of the two-dimensional bin.
   assign row = req_pos_channel >> BIN_SHIFT;
   assign col = req_energy_channel >> BIN_SHIFT;

   // The gate box bounds are exclusive on all four sides.
   assign in_box = (req_pos_channel > gate_cfg.min_pos) &&
                   (req_pos_channel < gate_cfg.max_pos) &&
                   (req_energy_channel > gate_cfg.min_energy) &&
                   (req_energy_channel < gate_cfg.max_energy);

   assign addr_1d_ok = 32'(req_read_address) < BINS_1D;
   assign addr_2d_ok = 32'(req_read_address) < BINS_2D;

   // Build the command; the unused opcode is accepted and dropped.
   always_comb begin
      push_cmd.kind            = CMD_EVENT;
      push_cmd.spectrum_select = req_spectrum_select;
      push_cmd.pos_ok          = 32'(req_pos_channel) < BINS_1D;
      push_cmd.energy_ok       = 32'(req_energy_channel) < BINS_1D;
      push_cmd.pair_ok         = (32'(row) < BINS_2D_SIDE) && (32'(col) < BINS_2D_SIDE);
      push_cmd.gate_hit        = gate_cfg.enable && in_box;
      push_cmd.pos_channel     = req_pos_channel;
      push_cmd.energy_channel  = req_energy_channel;
      push_cmd.read_address    = req_read_address;
      known_op                 = 1'b1;
      unique case (req_opcode)
         OP_EVENT: begin
            push_cmd.kind = CMD_EVENT;
         end
         OP_READ: begin
            push_cmd.kind = CMD_READ;
         end
         OP_CLEAR: begin
            push_cmd.kind = CMD_CLEAR;
         end
         OP_UNUSED: begin
            known_op = 1'b0;
         end
      endcase
      unique case (req_spectrum_select)
         SEL_POS, SEL_ENERGY: begin
            push_cmd.read_ok = addr_1d_ok;
         end
         SEL_PAIR, SEL_GATED: begin
            push_cmd.read_ok = addr_2d_ok;
         end
      endcase
   end

endmodule

FILE: src/geh_cmd_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on geh_pkg for the command type and the queue depth.
module geh_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  geh_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output geh_pkg::cmd_type pop_cmd
);
   import geh_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               push_xfer;
   logic               pop_xfer;

   assign push_ready = 32'(count_ff) < QUEUE_DEPTH;
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push_xfer  = push_valid && push_ready;
   assign pop_xfer   = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_xfer) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_xfer) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_xfer && !pop_xfer) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_xfer && !push_xfer) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push_xfer) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: src/geh_back.sv
// Back end of the histogrammer: spectrum memories, update sequencer and response register.
// Depends on geh_pkg; takes classified commands from geh_cmd_queue.
module geh_back #(
   parameter int BINS_1D      = 4096,
   parameter int BINS_2D_SIDE = 256,
   parameter int BIN_SHIFT    = 4,
   parameter int COUNT_BITS   = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  geh_pkg::cmd_type         pop_cmd,
   output logic                     back_busy,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [geh_pkg::OUT_W-1:0] rsp_bin_count
);
   import geh_pkg::*;

   localparam int BINS_2D     = BINS_2D_SIDE * BINS_2D_SIDE;
   localparam int AW1         = $clog2(BINS_1D);
   localparam int AW2         = $clog2(BINS_2D);
   localparam int SWEEP_DEPTH = (BINS_1D > BINS_2D) ? BINS_1D : BINS_2D;
   localparam int SW          = $clog2(SWEEP_DEPTH);
   localparam logic [SW-1:0] SWEEP_LAST = SW'(SWEEP_DEPTH - 1);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_RESULT = 4'b1000
   } state_type;

   // Spectrum memories.
   logic [COUNT_BITS-1:0] pos_mem    [BINS_1D];
   logic [COUNT_BITS-1:0] energy_mem [BINS_1D];
   logic [COUNT_BITS-1:0] pair_mem   [BINS_2D];
   logic [COUNT_BITS-1:0] gated_mem  [BINS_2D];

   logic [COUNT_BITS-1:0] pos_rd_ff;
   logic [COUNT_BITS-1:0] energy_rd_ff;
   logic [COUNT_BITS-1:0] pair_rd_ff;
   logic [COUNT_BITS-1:0] gated_rd_ff;

   state_type         state_ff;
   state_type         state_in;
   logic [SW-1:0]     sweep_ff;
   logic [SW-1:0]     sweep_in;
   cmd_type           cmd_ff;
   cmd_type           cmd_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [OUT_W-1:0]  rsp_data_ff;
   logic [OUT_W-1:0]  rsp_data_in;

   logic              clearing;
   logic              updating;
   logic              mem_re;
   logic              rsp_load;
   logic              sweep_in_1d;
   logic              sweep_in_2d;
   logic [CH_W-1:0]   pop_row;
   logic [CH_W-1:0]   pop_col;
   logic [CH_W-1:0]   cmd_row;
   logic [CH_W-1:0]   cmd_col;
   logic [AW1-1:0]    pos_raddr;
   logic [AW1-1:0]    energy_raddr;
   logic [AW2-1:0]    pair_raddr;
   logic [AW1-1:0]    pos_waddr;
   logic [AW1-1:0]    energy_waddr;
   logic [AW2-1:0]    pair_waddr;
   logic              pos_we;
   logic              energy_we;
   logic              pair_we;
   logic              gated_we;
   logic [COUNT_BITS-1:0] pos_wdata;
   logic [COUNT_BITS-1:0] energy_wdata;
   logic [COUNT_BITS-1:0] pair_wdata;
   logic [COUNT_BITS-1:0] gated_wdata;
   logic [COUNT_BITS-1:0] sel_count;

   assign clearing    = state_ff == ST_CLEAR;
   assign updating    = state_ff == ST_UPDATE;
   assign back_busy   = clearing;
   assign pop_ready   = state_ff == ST_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_bin_count = rsp_data_ff;
   assign sweep_in_1d = 32'(sweep_ff) < BINS_1D;
   assign sweep_in_2d = 32'(sweep_ff) < BINS_2D;
   assign rsp_load    = (state_ff == ST_RESULT) && (!rsp_valid_ff || rsp_ready);

   // Read addresses come from the command being taken off the queue.
   assign pop_row = pop_cmd.pos_channel >> BIN_SHIFT;
   assign pop_col = pop_cmd.energy_channel >> BIN_SHIFT;
   always_comb begin
      if (pop_cmd.kind == CMD_READ) begin
         pos_raddr    = AW1'(pop_cmd.read_address);
         energy_raddr = AW1'(pop_cmd.read_address);
         pair_raddr   = AW2'(pop_cmd.read_address);
      end else begin
         pos_raddr    = AW1'(pop_cmd.pos_channel);
         energy_raddr = AW1'(pop_cmd.energy_channel);
         pair_raddr   = AW2'(32'(pop_row) * BINS_2D_SIDE + 32'(pop_col));
      end
   end

   // Write addresses come from the sweep counter or the held event.
   assign cmd_row = cmd_ff.pos_channel >> BIN_SHIFT;
   assign cmd_col = cmd_ff.energy_channel >> BIN_SHIFT;
   always_comb begin
      if (clearing) begin
         pos_waddr    = AW1'(sweep_ff);
         energy_waddr = AW1'(sweep_ff);
         pair_waddr   = AW2'(sweep_ff);
      end else begin
         pos_waddr    = AW1'(cmd_ff.pos_channel);
         energy_waddr = AW1'(cmd_ff.energy_channel);
         pair_waddr   = AW2'(32'(cmd_row) * BINS_2D_SIDE + 32'(cmd_col));
      end
   end

   // Write enables and saturating increments of the bins read in the previous cycle.
   assign pos_we    = (clearing && sweep_in_1d) || (updating && cmd_ff.pos_ok);
   assign energy_we = (clearing && sweep_in_1d) || (updating && cmd_ff.energy_ok);
   assign pair_we   = (clearing && sweep_in_2d) || (updating && cmd_ff.pair_ok);
   assign gated_we  = (clearing && sweep_in_2d) ||
                      (updating && cmd_ff.pair_ok && cmd_ff.gate_hit);

   assign pos_wdata    = clearing ? '0 :
                         ((pos_rd_ff == '1) ? pos_rd_ff : pos_rd_ff + COUNT_BITS'(1));
   assign energy_wdata = clearing ? '0 :
                         ((energy_rd_ff == '1) ? energy_rd_ff : energy_rd_ff + COUNT_BITS'(1));
   assign pair_wdata   = clearing ? '0 :
                         ((pair_rd_ff == '1) ? pair_rd_ff : pair_rd_ff + COUNT_BITS'(1));
   assign gated_wdata  = clearing ? '0 :
                         ((gated_rd_ff == '1) ? gated_rd_ff : gated_rd_ff + COUNT_BITS'(1));

   // Sequencer: sweep, take a command, update bins or form a response.
   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      cmd_in   = cmd_ff;
      mem_re   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            sweep_in = sweep_ff + SW'(1);
            if (sweep_ff == SWEEP_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (pop_valid) begin
               cmd_in = pop_cmd;
               unique case (pop_cmd.kind)
                  CMD_EVENT: begin
                     mem_re   = 1'b1;
                     state_in = ST_UPDATE;
                  end
                  CMD_READ: begin
                     mem_re   = 1'b1;
                     state_in = ST_RESULT;
                  end
                  CMD_CLEAR: begin
                     sweep_in = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         ST_RESULT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Select the requested bin; an address beyond the spectrum reads as zero.
   always_comb begin
      unique case (cmd_ff.spectrum_select)
         SEL_POS:    sel_count = pos_rd_ff;
         SEL_ENERGY: sel_count = energy_rd_ff;
         SEL_PAIR:   sel_count = pair_rd_ff;
         SEL_GATED:  sel_count = gated_rd_ff;
      endcase
      rsp_data_in = cmd_ff.read_ok ? OUT_W'(sel_count) : '0;
   end

   // The response register holds until the transfer completes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // One write port and one registered read port per memory.
   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_waddr] <= pos_wdata;
      end
      if (mem_re) begin
         pos_rd_ff <= pos_mem[pos_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (energy_we) begin
         energy_mem[energy_waddr] <= energy_wdata;
      end
      if (mem_re) begin
         energy_rd_ff <= energy_mem[energy_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (pair_we) begin
         pair_mem[pair_waddr] <= pair_wdata;
      end
      if (mem_re) begin
         pair_rd_ff <= pair_mem[pair_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (gated_we) begin
         gated_mem[pair_waddr] <= gated_wdata;
      end
      if (mem_re) begin
         gated_rd_ff <= gated_mem[pair_raddr];
      end
   end

endmodule

FILE: src/gated_event_histogrammer.sv
// Gated event histogrammer. For each event the back end first reads the four spectrum bins
// and then writes the saturated increments back, taking no new command until the write is
// done; a read fetches the bins and then waits for the response register to be free.
// A two-entry queue lets requests arrive while the back end is busy. Clearing sweeps all
// four memories in parallel, one bin a cycle, until every bin of each spectrum is zero; the
// same sweep runs after reset, and no request is accepted while it is in progress. The user
// must write gate registers through the csr_ port only while idle, which is not enforced.
// Top level; depends on geh_pkg, geh_front, geh_cmd_queue, geh_back and the macro header.
`include "gated_event_histogrammer_macros.svh"

module gated_event_histogrammer #(
   parameter int BINS_1D      = 4096,
   parameter int BINS_2D_SIDE = 256,
   parameter int BIN_SHIFT    = 4,
   parameter int COUNT_BITS   = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_opcode,
   input  logic [geh_pkg::CH_W-1:0]      req_pos_channel,
   input  logic [geh_pkg::CH_W-1:0]      req_energy_channel,
   input  logic [1:0]                    req_spectrum_select,
   input  logic [geh_pkg::ADDR_W-1:0]    req_read_address,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [geh_pkg::OUT_W-1:0]     rsp_bin_count,
   input  logic                          csr_write_enable,
   input  logic [geh_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [geh_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import geh_pkg::*;

   gate_cfg_type gate_cfg_ff;
   gate_cfg_type gate_cfg_in;
   logic         back_busy;
   logic         q_push_valid;
   logic         q_push_ready;
   cmd_type      q_push_cmd;
   logic         q_pop_valid;
   logic         q_pop_ready;
   cmd_type      q_pop_cmd;

   // Gate configuration registers; writes beyond the list are ignored.
   always_comb begin
      gate_cfg_in = gate_cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_GATE_ENABLE:     gate_cfg_in.enable     = csr_wdata[0];
            CSR_GATE_MIN_POS:    gate_cfg_in.min_pos    = csr_wdata[CH_W-1:0];
            CSR_GATE_MAX_POS:    gate_cfg_in.max_pos    = csr_wdata[CH_W-1:0];
            CSR_GATE_MIN_ENERGY: gate_cfg_in.min_energy = csr_wdata[CH_W-1:0];
            CSR_GATE_MAX_ENERGY: gate_cfg_in.max_energy = csr_wdata[CH_W-1:0];
            default:             gate_cfg_in = gate_cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_cfg_ff <= '0;
      end else begin
         gate_cfg_ff <= gate_cfg_in;
      end
   end

   // Request classification.
   geh_front #(
      .BINS_1D      (BINS_1D),
      .BINS_2D_SIDE (BINS_2D_SIDE),
      .BIN_SHIFT    (BIN_SHIFT)
   ) u_front (
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_pos_channel     (req_pos_channel),
      .req_energy_channel  (req_energy_channel),
      .req_spectrum_select (req_spectrum_select),
      .req_read_address    (req_read_address),
      .gate_cfg            (gate_cfg_ff),
      .back_busy           (back_busy),
      .push_valid          (q_push_valid),
      .push_ready          (q_push_ready),
      .push_cmd            (q_push_cmd)
   );

   // Decoupling queue.
   geh_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_cmd   (q_push_cmd),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_cmd    (q_pop_cmd)
   );

   // Spectrum memories and update sequencer.
   geh_back #(
      .BINS_1D      (BINS_1D),
      .BINS_2D_SIDE (BINS_2D_SIDE),
      .BIN_SHIFT    (BIN_SHIFT),
      .COUNT_BITS   (COUNT_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (q_pop_valid),
      .pop_ready     (q_pop_ready),
      .pop_cmd       (q_pop_cmd),
      .back_busy     (back_busy),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_bin_count (rsp_bin_count)
   );

   // No request transfer may complete while the spectra are being cleared.
   `GEH_ASSERT_SAME(a_no_accept_in_sweep, clock, reset, back_busy, !(req_valid && req_ready), "request accepted during clearing sweep")
   // The queue is not drained while the sweep runs.
   `GEH_ASSERT_SAME(a_no_pop_in_sweep, clock, reset, back_busy, !q_pop_ready, "command taken during clearing sweep")
   // Taking a clear command starts the sweep in the next cycle.
   `GEH_ASSERT_NEXT(a_clear_starts_sweep, clock, reset, q_pop_valid && q_pop_ready && (q_pop_cmd.kind == CMD_CLEAR), back_busy, "clear command did not start a sweep")

endmodule
